[rtl/timer_with_compare_capture_top_defines.svh]
// Assertion macros shared by the timer with compare and capture channels.
// Needs no other file; the modules that check their own logic include it.
`ifndef TIMER_WITH_COMPARE_CAPTURE_TOP_DEFINES_SVH
`define TIMER_WITH_COMPARE_CAPTURE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked at every rising clock edge outside reset.
`define TCC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define TCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/tcc_pkg.sv]
// Types and constants of the timer with compare and capture channels.
// Used by tcc_core and timer_with_compare_capture_top; depends on nothing.
package tcc_pkg;

	// Item kinds.
	localparam logic [2:0] MODE_TICK       = 3'd0;
	localparam logic [2:0] MODE_LOAD_TIMER = 3'd1;
	localparam logic [2:0] MODE_LOAD_CMP1  = 3'd2;
	localparam logic [2:0] MODE_LOAD_CMP2  = 3'd3;
	localparam logic [2:0] MODE_LOAD_CMP3  = 3'd4;
	localparam logic [2:0] MODE_CLEAR      = 3'd5;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 6;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMER_CONTROL = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CHAN1_MODE    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CHAN2_MODE    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CHAN3_MODE    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CHAN_PRESENT  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_OUT_ENABLE    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ADC_ON        = 3'd6;

	// Timer clock source, timer_control bits 1:0.
	localparam logic [1:0] SRC_INTERNAL = 2'b01;
	localparam logic [1:0] SRC_EXTERNAL = 2'b11;

	// Channel function, mode bits 3:2.
	localparam logic [1:0] FN_CAPTURE = 2'b01;
	localparam logic [1:0] FN_COMPARE = 2'b10;

	// Compare submodes, mode bits 1:0.
	localparam logic [1:0] CMP_SET     = 2'd0;
	localparam logic [1:0] CMP_CLEAR   = 2'd1;
	localparam logic [1:0] CMP_FLAG    = 2'd2;
	localparam logic [1:0] CMP_SPECIAL = 2'd3;

	// Capture submodes, mode bits 1:0.
	localparam logic [1:0] CAP_FALL    = 2'd0;
	localparam logic [1:0] CAP_RISE    = 2'd1;
	localparam logic [1:0] CAP_EVERY4  = 2'd2;
	localparam logic [1:0] CAP_EVERY16 = 2'd3;

	localparam logic [3:0] CAP_EVERY4_HIT = 4'd4;

	typedef struct packed {
		logic [5:0]      timer_control;
		logic [2:0][3:0] chan_mode;
		logic [2:0]      chan_present;
		logic [2:0]      out_enable;
		logic            adc_on;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] load_value;
		logic        ext_clock_level;
		logic        chan1_pin;
		logic        chan2_pin;
	} in_item_t;

	typedef struct packed {
		logic [15:0] timer_value;
		logic [15:0] chan1_value;
		logic [15:0] chan2_value;
		logic        overflow_flag;
		logic        chan1_flag;
		logic        chan2_flag;
		logic        chan3_flag;
		logic [2:0]  chan_outputs;
		logic        adc_start;
	} out_item_t;

	// Prescaler division ratio for timer_control bits 5:4.
	function automatic logic [3:0] presc_div(input logic [1:0] sel);
		logic [3:0] d;
		case (sel)
			2'd0: d = 4'd1;
			2'd1: d = 4'd2;
			2'd2: d = 4'd4;
			default: d = 4'd8;
		endcase
		return d;
	endfunction

endpackage

[rtl/tcc_core.sv]
// State registers and per-item update of the timer, compare and capture channels.
// Depends on tcc_pkg for the item, result and configuration types.
module tcc_core #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  tcc_pkg::in_item_t    item,
	input  tcc_pkg::cfg_t        cfg,
	output tcc_pkg::out_item_t   result
);

	localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	logic [TIMER_BITS-1:0] count_q, count_n;
	logic [3:0]            psc_q, psc_n;
	logic                  prev_ext_q, prev_ext_n;
	logic [2:0][15:0]      vals_q, vals_n;
	logic [1:0][3:0]       cap_psc_q, cap_psc_n;
	logic [1:0]            prev_pin_q, prev_pin_n;
	logic [3:0]            flags_q, flags_n;
	logic [2:0]            levels_q, levels_n;
	logic                  adc;
	logic [CMP_W-1:0]      count_ext;
	logic [CMP_W-1:0]      load_ext;

	always_comb begin
		logic       counting;
		logic       fire;
		logic [3:0] cp;
		logic [1:0] pins;
		logic [1:0] src;
		count_n    = count_q;
		psc_n      = psc_q;
		prev_ext_n = prev_ext_q;
		vals_n     = vals_q;
		cap_psc_n  = cap_psc_q;
		prev_pin_n = prev_pin_q;
		flags_n    = flags_q;
		levels_n   = levels_q;
		adc        = 1'b0;
		fire       = 1'b0;
		cp         = 4'd0;
		pins       = {item.chan2_pin, item.chan1_pin};
		src        = cfg.timer_control[1:0];
		counting   = (src == tcc_pkg::SRC_INTERNAL) ||
			(src == tcc_pkg::SRC_EXTERNAL && !prev_ext_q && item.ext_clock_level);
		load_ext   = CMP_W'(item.load_value);
		count_ext  = CMP_W'(count_q);
		if (go) begin
			case (item.mode)
				tcc_pkg::MODE_TICK: begin
					if (counting) begin
						psc_n = psc_q + 4'd1;
						if (psc_n >= tcc_pkg::presc_div(cfg.timer_control[5:4])) begin
							count_n = count_q + TIMER_BITS'(1);
							if (count_n == '0) begin
								flags_n[0] = 1'b1;
							end
							psc_n = 4'd0;
						end
						// Channels are checked in order; a special event resets
						// the count that the later channels then see.
						for (int ch = 0; ch < 3; ch++) begin
							if (cfg.chan_present[ch] &&
								cfg.chan_mode[ch][3:2] == tcc_pkg::FN_COMPARE &&
								CMP_W'(count_n) == CMP_W'(vals_n[ch])) begin
								flags_n[ch+1] = 1'b1;
								case (cfg.chan_mode[ch][1:0])
									tcc_pkg::CMP_SET: begin
										if (cfg.out_enable[ch]) levels_n[ch] = 1'b1;
									end
									tcc_pkg::CMP_CLEAR: begin
										if (cfg.out_enable[ch]) levels_n[ch] = 1'b0;
									end
									tcc_pkg::CMP_FLAG: begin
									end
									default: begin
										count_n = '0;
										if (ch == 1 && cfg.adc_on) adc = 1'b1;
									end
								endcase
							end
						end
					end
					prev_ext_n = item.ext_clock_level;
					count_ext  = CMP_W'(count_n);
					if (cfg.timer_control[0]) begin
						for (int ch = 0; ch < 2; ch++) begin
							if (cfg.chan_present[ch] &&
								cfg.chan_mode[ch][3:2] == tcc_pkg::FN_CAPTURE &&
								pins[ch] != prev_pin_q[ch]) begin
								fire = 1'b0;
								case (cfg.chan_mode[ch][1:0])
									tcc_pkg::CAP_FALL: fire = prev_pin_q[ch];
									tcc_pkg::CAP_RISE: fire = !prev_pin_q[ch];
									default: begin
										if (!prev_pin_q[ch]) begin
											cp = cap_psc_q[ch] + 4'd1;
											if ((cfg.chan_mode[ch][1:0] == tcc_pkg::CAP_EVERY4) ?
												(cp == tcc_pkg::CAP_EVERY4_HIT) : (cp == 4'd0)) begin
												fire = 1'b1;
												cp   = 4'd0;
											end
											cap_psc_n[ch] = cp;
										end
									end
								endcase
								if (fire) begin
									flags_n[ch+1] = 1'b1;
									vals_n[ch]    = count_ext[15:0];
								end
								prev_pin_n[ch] = pins[ch];
							end
						end
					end
				end
				tcc_pkg::MODE_LOAD_TIMER: begin
					count_n   = load_ext[TIMER_BITS-1:0];
					count_ext = CMP_W'(count_n);
				end
				tcc_pkg::MODE_LOAD_CMP1: vals_n[0] = item.load_value;
				tcc_pkg::MODE_LOAD_CMP2: vals_n[1] = item.load_value;
				tcc_pkg::MODE_LOAD_CMP3: vals_n[2] = item.load_value;
				tcc_pkg::MODE_CLEAR: flags_n = flags_q & ~item.load_value[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			psc_q      <= '0;
			prev_ext_q <= 1'b0;
			vals_q     <= '0;
			cap_psc_q  <= '0;
			prev_pin_q <= '0;
			flags_q    <= '0;
			levels_q   <= '0;
		end else if (go) begin
			count_q    <= count_n;
			psc_q      <= psc_n;
			prev_ext_q <= prev_ext_n;
			vals_q     <= vals_n;
			cap_psc_q  <= cap_psc_n;
			prev_pin_q <= prev_pin_n;
			flags_q    <= flags_n;
			levels_q   <= levels_n;
		end
	end

	assign result.timer_value   = count_ext[15:0];
	assign result.chan1_value   = vals_n[0];
	assign result.chan2_value   = vals_n[1];
	assign result.overflow_flag = flags_n[0];
	assign result.chan1_flag    = flags_n[1];
	assign result.chan2_flag    = flags_n[2];
	assign result.chan3_flag    = flags_n[3];
	assign result.chan_outputs  = levels_n;
	assign result.adc_start     = adc;

endmodule

[rtl/timer_with_compare_capture_top.sv]
// Top level of the timer with compare and capture channels: handshake, config.
// Depends on tcc_pkg, tcc_core and timer_with_compare_capture_top_defines.svh.
//
// Usage: items arrive on the in_valid/in_stall channel; a transfer happens at a
// rising edge with in_valid high and in_stall low. Each item (tick, timer load,
// compare value load or flag clear) gives exactly one result on the
// out_valid/out_stall channel, in order. Configuration registers are written
// through cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high, and writes are expected only while no item is in flight.
// Path: an item taken is registered in the input stage, processed by the core
// once the result register is free, and its result is registered there and
// offered on out_valid/out_stall. Throughput: one item per cycle while the
// receiver does not stall. The timer, compare and capture update is a single
// pass of logic between the input stage and the result register. Reset clears
// the timer, channel state, flags, output levels, configuration and both
// stages. When the receiver stalls, the result register holds and the input
// stage takes one more item; then in_stall rises until the result moves.
`include "timer_with_compare_capture_top_defines.svh"
module timer_with_compare_capture_top #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  tcc_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output tcc_pkg::out_item_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tcc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	tcc_pkg::cfg_t      cfg_q;
	tcc_pkg::in_item_t  item_s1;
	logic               valid_s1;
	tcc_pkg::out_item_t result_s2;
	logic               valid_s2;
	tcc_pkg::out_item_t result;
	logic               out_free;
	logic               go;

	// The result register can take a new result when it is empty or its
	// current result transfers at this edge.
	assign out_free  = !valid_s2 || !out_stall;
	assign go        = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tcc_pkg::REG_TIMER_CONTROL: cfg_q.timer_control <= cfg_data;
				tcc_pkg::REG_CHAN1_MODE:    cfg_q.chan_mode[0]  <= cfg_data[3:0];
				tcc_pkg::REG_CHAN2_MODE:    cfg_q.chan_mode[1]  <= cfg_data[3:0];
				tcc_pkg::REG_CHAN3_MODE:    cfg_q.chan_mode[2]  <= cfg_data[3:0];
				tcc_pkg::REG_CHAN_PRESENT:  cfg_q.chan_present  <= cfg_data[2:0];
				tcc_pkg::REG_OUT_ENABLE:    cfg_q.out_enable    <= cfg_data[2:0];
				tcc_pkg::REG_ADC_ON:        cfg_q.adc_on        <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Input stage: holds one item until the core processes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	tcc_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// Result register: the state update and the result it reports land together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	`TCC_ASSERT(a_go_fills_result, clk, arst_n, go |=> valid_s2, "processed item has no result")
	`TCC_ASSERT(a_s1_holds, clk, arst_n, valid_s1 && !go |=> valid_s1 && $stable(item_s1), "waiting item lost or changed")
	`TCC_ASSERT(a_adc_tick_only, clk, arst_n, go && item_s1.mode != tcc_pkg::MODE_TICK |=> !result_s2.adc_start, "converter start on a non-tick item")
	`TCC_ASSERT_ALWAYS(a_stall_cause, clk, in_stall |-> valid_s2 && out_stall && valid_s1, "input stalled without a blocked result")

endmodule
